// File: rtl/dnms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnms_pkg
// Shared types and constants for the detection decode and suppression block.
// ----------------------------------------------------------------------------
package dnms_pkg;

   localparam int DET_DEPTH = 64;
   localparam int IDX_W     = $clog2(DET_DEPTH);
   localparam int CNT_W     = IDX_W + 1;
   localparam int CLS_MAX   = 4;

   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [2:0] REG_CONF_THR = 3'd0;
   localparam logic [2:0] REG_OVL_THR  = 3'd1;
   localparam logic [2:0] REG_INV_SCL  = 3'd2;
   localparam logic [2:0] REG_PAD_L    = 3'd3;
   localparam logic [2:0] REG_PAD_T    = 3'd4;
   localparam logic [2:0] REG_IMG_W    = 3'd5;
   localparam logic [2:0] REG_IMG_H    = 3'd6;
   localparam logic [2:0] REG_CLS_CNT  = 3'd7;

   typedef struct packed {
      logic [1:0]  cls;
      logic [15:0] score;
      logic [15:0] bottom;
      logic [15:0] right;
      logic [15:0] top;
      logic [15:0] left;
   } item_type;

   typedef struct packed {
      logic             item_we;
      logic [IDX_W-1:0] item_waddr;
      logic [IDX_W-1:0] item_raddr;
      logic             rank_we;
      logic [IDX_W-1:0] rank_waddr;
      logic [IDX_W-1:0] rank_wdata;
      logic [IDX_W-1:0] rank_raddr;
   } store_ctl_type;

endpackage
`default_nettype wire

// File: rtl/dnms_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnms_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dnms_mul (
   input  wire logic                                  clock,
   input  wire logic signed [dnms_pkg::MUL_A_W-1:0]   op_a,
   input  wire logic signed [dnms_pkg::MUL_B_W-1:0]   op_b,
   output logic signed      [dnms_pkg::PROD_W-1:0]    prod
);
   import dnms_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// File: rtl/dnms_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnms_store
// Candidate store and rank table, one write and one registered read each.
// ----------------------------------------------------------------------------
module dnms_store (
   input  wire logic                      clock,
   input  wire dnms_pkg::store_ctl_type   ctl,
   input  wire dnms_pkg::item_type        item_wdata,
   output dnms_pkg::item_type             item_rdata,
   output logic [dnms_pkg::IDX_W-1:0]     rank_rdata
);
   import dnms_pkg::*;

   item_type         item_mem [DET_DEPTH];
   logic [IDX_W-1:0] rank_mem [DET_DEPTH];
   item_type         item_rd_ff;
   logic [IDX_W-1:0] rank_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.item_we) begin
         item_mem[ctl.item_waddr] <= item_wdata;
      end
      item_rd_ff <= item_mem[ctl.item_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.rank_we) begin
         rank_mem[ctl.rank_waddr] <= ctl.rank_wdata;
      end
      rank_rd_ff <= rank_mem[ctl.rank_raddr];
   end

   assign item_rdata = item_rd_ff;
   assign rank_rdata = rank_rd_ff;

endmodule
`default_nettype wire

// File: rtl/detection_decode_and_nms.sv
`default_nettype none
// ----------------------------------------------------------------------------
// detection_decode_and_nms
// Decodes detector proposals, keeps up to 64 candidates and runs class-aware
// greedy suppression at the end of each frame.
//
// Input beats (req_) carry one proposal each. A kept proposal is decoded in
// four passes through one shared multiplier and written to the store; a
// dropped one is not. req_ready is low meanwhile. On a beat with frame_end
// the block ranks the n stored boxes by score compares, then walks them for
// suppression, using up to three multiplier passes per compared pair, scans
// the marks and emits the survivors in rank order on the rsp_ channel, or one
// none_kept beat when nothing survived. A stalled rsp_ready holds the output
// register and the emission walk; after the final beat is loaded the block
// finishes the rank walk, clears the frame and then takes new proposals.
// Reset loads the register defaults, empties the store and drops any
// pending result. The user must write registers through the APB port only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module detection_decode_and_nms (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_center_x,
   input  wire logic signed [15:0] req_center_y,
   input  wire logic [14:0]        req_box_width,
   input  wire logic [14:0]        req_box_height,
   input  wire logic [15:0]        req_score_zero,
   input  wire logic [15:0]        req_score_one,
   input  wire logic [15:0]        req_score_two,
   input  wire logic [15:0]        req_score_three,
   input  wire logic               req_frame_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_class_index,
   output logic [15:0]             rsp_confidence,
   output logic [15:0]             rsp_left,
   output logic [15:0]             rsp_top,
   output logic [15:0]             rsp_right,
   output logic [15:0]             rsp_bottom,
   output logic                    rsp_final_result,
   output logic                    rsp_none_kept,
   output logic                    rsp_store_overflowed,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import dnms_pkg::*;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_DEC     = 5'd1;
   localparam logic [4:0] ST_WR      = 5'd2;
   localparam logic [4:0] ST_SRT_A   = 5'd3;
   localparam logic [4:0] ST_SRT_B   = 5'd4;
   localparam logic [4:0] ST_SRT_C   = 5'd5;
   localparam logic [4:0] ST_SRT_D   = 5'd6;
   localparam logic [4:0] ST_SRT_W   = 5'd7;
   localparam logic [4:0] ST_SUP_A0  = 5'd8;
   localparam logic [4:0] ST_SUP_A1  = 5'd9;
   localparam logic [4:0] ST_SUP_A2  = 5'd10;
   localparam logic [4:0] ST_SUP_A3  = 5'd11;
   localparam logic [4:0] ST_SUP_B0  = 5'd12;
   localparam logic [4:0] ST_SUP_B1  = 5'd13;
   localparam logic [4:0] ST_SUP_B2  = 5'd14;
   localparam logic [4:0] ST_SUP_B3  = 5'd15;
   localparam logic [4:0] ST_SUP_B4  = 5'd16;
   localparam logic [4:0] ST_SUP_B5  = 5'd17;
   localparam logic [4:0] ST_SUP_B6  = 5'd18;
   localparam logic [4:0] ST_SCAN    = 5'd19;
   localparam logic [4:0] ST_EM_0    = 5'd20;
   localparam logic [4:0] ST_EM_1    = 5'd21;
   localparam logic [4:0] ST_EM_2    = 5'd22;
   localparam logic [4:0] ST_EM_3    = 5'd23;
   localparam logic [4:0] ST_EM_NONE = 5'd24;
   localparam logic [4:0] ST_DONE    = 5'd25;

   // configuration
   logic [15:0] conf_thr_ff, conf_thr_in;
   logic [15:0] ovl_thr_ff, ovl_thr_in;
   logic [15:0] inv_scl_ff, inv_scl_in;
   logic [10:0] pad_l_ff, pad_l_in;
   logic [10:0] pad_t_ff, pad_t_in;
   logic [11:0] img_w_ff, img_w_in;
   logic [11:0] img_h_ff, img_h_in;
   logic [2:0]  cls_cnt_ff, cls_cnt_in;

   // sequencer
   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [DET_DEPTH-1:0] marks_ff, marks_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      si_ff, si_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             any_ff, any_in;
   logic [2:0]       k_ff, k_in;
   logic             fend_ff, fend_in;

   // payload
   logic signed [15:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [14:0]        bw_ff, bw_in, bh_ff, bh_in;
   logic [15:0]        best_ff, best_in;
   logic [1:0]         bcls_ff, bcls_in;
   item_type           box_ff, box_in;
   item_type           a_ff, a_in;
   item_type           b_ff, b_in;
   logic signed [MUL_A_W-1:0] area_a_ff, area_a_in;
   logic signed [MUL_A_W-1:0] area_b_ff, area_b_in;
   logic signed [MUL_A_W-1:0] inter_ff, inter_in;
   logic signed [MUL_A_W-1:0] union_ff, union_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   item_type    out_ff, out_in;
   logic        out_final_ff, out_final_in;
   logic        out_none_ff, out_none_in;
   logic        out_ovf_ff, out_ovf_in;

   // datapath
   store_ctl_type             ctl;
   item_type                  item_rd;
   logic [IDX_W-1:0]          rank_rd;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic        cfg_we;
   logic [2:0]  cfg_idx;
   logic [2:0]  cls_n;
   logic [15:0] scores [CLS_MAX];
   logic [15:0] best;
   logic [1:0]  bcls;
   logic        accept;
   logic        out_free;

   logic signed [15:0] cen;
   logic [14:0]        sz;
   logic [10:0]        pad;
   logic signed [18:0] corner;
   logic [1:0]         km1;
   logic [11:0]        limit;
   logic [15:0]        bound;
   logic [33:0]        rsum;
   logic [20:0]        rnd;
   logic [15:0]        coord;
   logic signed [16:0] dx_rd, dy_rd, iw, ih;
   logic [15:0]        min_x2, max_x1, min_y2, max_y1;
   logic signed [PROD_W-1:0] inter_sh;

   dnms_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   dnms_store u_store (
      .clock      (clock),
      .ctl        (ctl),
      .item_wdata (box_ff),
      .item_rdata (item_rd),
      .rank_rdata (rank_rd)
   );

   assign pready  = 1'b1;
   assign cfg_we  = psel & penable & pwrite;
   assign cfg_idx = paddr[4:2];

   always_comb begin
      case (cfg_idx)
         REG_CONF_THR: prdata = {16'd0, conf_thr_ff};
         REG_OVL_THR:  prdata = {16'd0, ovl_thr_ff};
         REG_INV_SCL:  prdata = {16'd0, inv_scl_ff};
         REG_PAD_L:    prdata = {21'd0, pad_l_ff};
         REG_PAD_T:    prdata = {21'd0, pad_t_ff};
         REG_IMG_W:    prdata = {20'd0, img_w_ff};
         REG_IMG_H:    prdata = {20'd0, img_h_ff};
         REG_CLS_CNT:  prdata = {29'd0, cls_cnt_ff};
         default:      prdata = 32'd0;
      endcase
   end

   always_comb begin
      conf_thr_in = conf_thr_ff;
      ovl_thr_in  = ovl_thr_ff;
      inv_scl_in  = inv_scl_ff;
      pad_l_in    = pad_l_ff;
      pad_t_in    = pad_t_ff;
      img_w_in    = img_w_ff;
      img_h_in    = img_h_ff;
      cls_cnt_in  = cls_cnt_ff;
      if (cfg_we) begin
         case (cfg_idx)
            REG_CONF_THR: conf_thr_in = pwdata[15:0];
            REG_OVL_THR:  ovl_thr_in  = pwdata[15:0];
            REG_INV_SCL:  inv_scl_in  = pwdata[15:0];
            REG_PAD_L:    pad_l_in    = pwdata[10:0];
            REG_PAD_T:    pad_t_in    = pwdata[10:0];
            REG_IMG_W:    img_w_in    = pwdata[11:0];
            REG_IMG_H:    img_h_in    = pwdata[11:0];
            REG_CLS_CNT:  cls_cnt_in  = pwdata[2:0];
            default:      ;
         endcase
      end
   end

   // best class, lowest index wins ties
   assign scores[0] = req_score_zero;
   assign scores[1] = req_score_one;
   assign scores[2] = req_score_two;
   assign scores[3] = req_score_three;

   always_comb begin
      if (cls_cnt_ff == 3'd0) begin
         cls_n = 3'd1;
      end else if (cls_cnt_ff > 3'(CLS_MAX)) begin
         cls_n = 3'(CLS_MAX);
      end else begin
         cls_n = cls_cnt_ff;
      end
      best = 16'd0;
      bcls = 2'd0;
      for (int c = 0; c < CLS_MAX; c++) begin
         if (3'(c) < cls_n && scores[c] > best) begin
            best = scores[c];
            bcls = 2'(c);
         end
      end
   end

   // corner decode operands
   always_comb begin
      cen    = k_ff[0] ? cy_ff : cx_ff;
      sz     = k_ff[0] ? bh_ff : bw_ff;
      pad    = k_ff[0] ? pad_t_ff : pad_l_ff;
      if (k_ff[1]) begin
         corner = {{2{cen[15]}}, cen, 1'b0} + $signed({4'd0, sz})
                  - $signed({3'd0, pad, 5'd0});
      end else begin
         corner = {{2{cen[15]}}, cen, 1'b0} - $signed({4'd0, sz})
                  - $signed({3'd0, pad, 5'd0});
      end
      km1   = 2'(k_ff - 3'd1);
      limit = km1[0] ? img_h_ff : img_w_ff;
      bound = {limit, 4'd0};
      rsum  = prod[33:0] + 34'd4096;
      rnd   = rsum[33:13];
      if (prod[34] || prod[33:0] == 34'd0) begin
         coord = 16'd0;
      end else if (rnd > {5'd0, bound}) begin
         coord = bound;
      end else begin
         coord = rnd[15:0];
      end
   end

   // overlap operands
   always_comb begin
      dx_rd  = $signed({1'b0, item_rd.right}) - $signed({1'b0, item_rd.left});
      dy_rd  = $signed({1'b0, item_rd.bottom}) - $signed({1'b0, item_rd.top});
      min_x2 = (a_ff.right < b_ff.right) ? a_ff.right : b_ff.right;
      max_x1 = (a_ff.left > b_ff.left) ? a_ff.left : b_ff.left;
      min_y2 = (a_ff.bottom < b_ff.bottom) ? a_ff.bottom : b_ff.bottom;
      max_y1 = (a_ff.top > b_ff.top) ? a_ff.top : b_ff.top;
      iw     = $signed({1'b0, min_x2}) - $signed({1'b0, max_x1});
      ih     = $signed({1'b0, min_y2}) - $signed({1'b0, max_y1});
      if (iw[16]) begin
         iw = 17'sd0;
      end
      if (ih[16]) begin
         ih = 17'sd0;
      end
      inter_sh = {inter_ff[MUL_A_W-1], inter_ff, 16'd0};
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      marks_in   = marks_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cnt_in     = cnt_ff;
      si_in      = si_ff;
      idx_in     = idx_ff;
      last_in    = last_ff;
      any_in     = any_ff;
      k_in       = k_ff;
      fend_in    = fend_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      bw_in      = bw_ff;
      bh_in      = bh_ff;
      best_in    = best_ff;
      bcls_in    = bcls_ff;
      box_in     = box_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      area_a_in  = area_a_ff;
      area_b_in  = area_b_ff;
      inter_in   = inter_ff;
      union_in   = union_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      out_in       = out_ff;
      out_final_in = out_final_ff;
      out_none_in  = out_none_ff;
      out_ovf_in   = out_ovf_ff;
      mul_a = '0;
      mul_b = '0;
      ctl   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cx_in   = req_center_x;
               cy_in   = req_center_y;
               bw_in   = req_box_width;
               bh_in   = req_box_height;
               best_in = best;
               bcls_in = bcls;
               box_in.cls   = bcls;
               box_in.score = best;
               fend_in = req_frame_end;
               k_in    = 3'd0;
               i_in    = '0;
               if (best >= conf_thr_ff && !count_ff[IDX_W]) begin
                  state_in = ST_DEC;
               end else begin
                  if (best >= conf_thr_ff) begin
                     ovf_in = 1'b1;
                  end
                  if (req_frame_end) begin
                     state_in = ST_SRT_A;
                  end
               end
            end
         end
         ST_DEC: begin
            mul_a = MUL_A_W'(corner);
            mul_b = $signed({1'b0, inv_scl_ff});
            if (k_ff != 3'd0) begin
               case (km1)
                  2'd0:    box_in.left   = coord;
                  2'd1:    box_in.top    = coord;
                  2'd2:    box_in.right  = coord;
                  default: box_in.bottom = coord;
               endcase
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd4) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            ctl.item_we    = 1'b1;
            ctl.item_waddr = count_ff[IDX_W-1:0];
            count_in       = count_ff + 1'b1;
            state_in       = fend_ff ? ST_SRT_A : ST_IDLE;
         end
         ST_SRT_A: begin
            ctl.item_raddr = i_ff[IDX_W-1:0];
            cnt_in = '0;
            if (i_ff == count_ff) begin
               i_in     = '0;
               state_in = ST_SUP_A0;
            end else begin
               state_in = ST_SRT_B;
            end
         end
         ST_SRT_B: begin
            si_in    = item_rd.score;
            j_in     = '0;
            state_in = ST_SRT_C;
         end
         ST_SRT_C: begin
            ctl.item_raddr = j_ff[IDX_W-1:0];
            state_in = ST_SRT_D;
         end
         ST_SRT_D: begin
            if (item_rd.score > si_ff || (item_rd.score == si_ff && j_ff < i_ff)) begin
               cnt_in = cnt_ff + 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == count_ff) ? ST_SRT_W : ST_SRT_C;
         end
         ST_SRT_W: begin
            ctl.rank_we    = 1'b1;
            ctl.rank_waddr = cnt_ff;
            ctl.rank_wdata = i_ff[IDX_W-1:0];
            i_in     = i_ff + 1'b1;
            state_in = ST_SRT_A;
         end
         ST_SUP_A0: begin
            ctl.rank_raddr = i_ff[IDX_W-1:0];
            if (i_ff == count_ff) begin
               i_in     = '0;
               any_in   = 1'b0;
               state_in = ST_SCAN;
            end else if (marks_ff[i_ff[IDX_W-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = ST_SUP_A1;
            end
         end
         ST_SUP_A1: begin
            ctl.item_raddr = rank_rd;
            state_in = ST_SUP_A2;
         end
         ST_SUP_A2: begin
            a_in     = item_rd;
            mul_a    = MUL_A_W'(dx_rd);
            mul_b    = dy_rd;
            state_in = ST_SUP_A3;
         end
         ST_SUP_A3: begin
            area_a_in = prod[MUL_A_W-1:0];
            j_in      = i_ff + 1'b1;
            state_in  = ST_SUP_B0;
         end
         ST_SUP_B0: begin
            ctl.rank_raddr = j_ff[IDX_W-1:0];
            if (j_ff == count_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SUP_A0;
            end else if (marks_ff[j_ff[IDX_W-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_SUP_B1;
            end
         end
         ST_SUP_B1: begin
            ctl.item_raddr = rank_rd;
            state_in = ST_SUP_B2;
         end
         ST_SUP_B2: begin
            b_in = item_rd;
            if (item_rd.cls != a_ff.cls) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_SUP_B0;
            end else begin
               mul_a    = MUL_A_W'(dx_rd);
               mul_b    = dy_rd;
               state_in = ST_SUP_B3;
            end
         end
         ST_SUP_B3: begin
            area_b_in = prod[MUL_A_W-1:0];
            mul_a     = MUL_A_W'(iw);
            mul_b     = ih;
            state_in  = ST_SUP_B4;
         end
         ST_SUP_B4: begin
            inter_in = prod[MUL_A_W-1:0];
            union_in = area_a_ff + area_b_ff - prod[MUL_A_W-1:0];
            state_in = ST_SUP_B5;
         end
         ST_SUP_B5: begin
            mul_a    = union_ff;
            mul_b    = $signed({1'b0, ovl_thr_ff});
            state_in = ST_SUP_B6;
         end
         ST_SUP_B6: begin
            if (union_ff > 0 && inter_sh > prod) begin
               marks_in[j_ff[IDX_W-1:0]] = 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_SUP_B0;
         end
         ST_SCAN: begin
            if (i_ff == count_ff) begin
               i_in     = '0;
               state_in = any_ff ? ST_EM_0 : ST_EM_NONE;
            end else begin
               if (!marks_ff[i_ff[IDX_W-1:0]]) begin
                  last_in = i_ff[IDX_W-1:0];
                  any_in  = 1'b1;
               end
               i_in = i_ff + 1'b1;
            end
         end
         ST_EM_0: begin
            ctl.rank_raddr = i_ff[IDX_W-1:0];
            if (i_ff == count_ff) begin
               state_in = ST_DONE;
            end else if (marks_ff[i_ff[IDX_W-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = ST_EM_1;
            end
         end
         ST_EM_1: begin
            idx_in   = rank_rd;
            state_in = ST_EM_2;
         end
         ST_EM_2: begin
            ctl.item_raddr = idx_ff;
            state_in = ST_EM_3;
         end
         ST_EM_3: begin
            ctl.item_raddr = idx_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_in       = item_rd;
               out_final_in = (i_ff[IDX_W-1:0] == last_ff);
               out_none_in  = 1'b0;
               out_ovf_in   = ovf_ff;
               i_in         = i_ff + 1'b1;
               state_in     = ST_EM_0;
            end
         end
         ST_EM_NONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_in       = '0;
               out_final_in = 1'b1;
               out_none_in  = 1'b1;
               out_ovf_in   = ovf_ff;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            count_in = '0;
            ovf_in   = 1'b0;
            marks_in = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_thr_ff  <= 16'd16384;
         ovl_thr_ff   <= 16'd29491;
         inv_scl_ff   <= 16'd4096;
         pad_l_ff     <= 11'd0;
         pad_t_ff     <= 11'd0;
         img_w_ff     <= 12'd640;
         img_h_ff     <= 12'd640;
         cls_cnt_ff   <= 3'd1;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         conf_thr_ff  <= conf_thr_in;
         ovl_thr_ff   <= ovl_thr_in;
         inv_scl_ff   <= inv_scl_in;
         pad_l_ff     <= pad_l_in;
         pad_t_ff     <= pad_t_in;
         img_w_ff     <= img_w_in;
         img_h_ff     <= img_h_in;
         cls_cnt_ff   <= cls_cnt_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      cnt_ff       <= cnt_in;
      si_ff        <= si_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      any_ff       <= any_in;
      k_ff         <= k_in;
      fend_ff      <= fend_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      bw_ff        <= bw_in;
      bh_ff        <= bh_in;
      best_ff      <= best_in;
      bcls_ff      <= bcls_in;
      box_ff       <= box_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      area_a_ff    <= area_a_in;
      area_b_ff    <= area_b_in;
      inter_ff     <= inter_in;
      union_ff     <= union_in;
      out_ff       <= out_in;
      out_final_ff <= out_final_in;
      out_none_ff  <= out_none_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_class_index      = out_ff.cls;
   assign rsp_confidence       = out_ff.score;
   assign rsp_left             = out_ff.left;
   assign rsp_top              = out_ff.top;
   assign rsp_right            = out_ff.right;
   assign rsp_bottom           = out_ff.bottom;
   assign rsp_final_result     = out_final_ff;
   assign rsp_none_kept        = out_none_ff;
   assign rsp_store_overflowed = out_ovf_ff;

endmodule
`default_nettype wire

// File: rtl/dnms_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnms_check
// Port-level checks for the detection decode and suppression block.
// ----------------------------------------------------------------------------
module dnms_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_confidence,
   input wire logic [15:0] rsp_left,
   input wire logic [15:0] rsp_right,
   input wire logic        rsp_final_result,
   input wire logic        rsp_none_kept
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_confidence))
      else $error("rsp beat dropped or changed while stalled");

   a_none_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_kept |-> rsp_final_result && rsp_confidence == 16'd0
         && rsp_left == 16'd0 && rsp_right == 16'd0)
      else $error("empty-frame beat malformed");

   a_ready_final: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_final_result)
      else $error("accepting proposals while frame results pending");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind detection_decode_and_nms dnms_check u_dnms_check (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_confidence   (rsp_confidence),
   .rsp_left         (rsp_left),
   .rsp_right        (rsp_right),
   .rsp_final_result (rsp_final_result),
   .rsp_none_kept    (rsp_none_kept)
);
`default_nettype wire
